/* rtl/pbpd_pkg.sv */
// Shared types and constants for the pulse burst pattern decoder.
`default_nettype none
package pbpd_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned TALLY_W   = 8;
    localparam int unsigned PAIR_W    = 64;
    localparam int unsigned SLOT_WORD_W = 32;
    localparam int unsigned PAIR_COUNT = 3;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [TALLY_W-1:0] TALLY_LIMIT = 8'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TOLERANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_PAIR_0  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_PAIR_1  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_PAIR_2  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEB,
        ST_GAP,
        ST_DIV,
        ST_SCAN,
        ST_FIN
    } pbpd_state_t;

    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [TALLY_W-1:0]  divisor;
    } pbpd_div_req_t;

endpackage
`default_nettype wire

/* rtl/pbpd_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module pbpd_div
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pbpd_pkg::pbpd_div_req_t req,
    output logic                        done,
    output logic [pbpd_pkg::TIME_W-1:0] quotient
);
    import pbpd_pkg::*;

    localparam int unsigned CNT_W = $clog2(TIME_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   quo_reg, quo_next;
    logic [TALLY_W-1:0]  rem_reg, rem_next;
    logic [TALLY_W-1:0]  dvs_reg, dvs_next;
    logic [TALLY_W:0]    shifted;
    logic [TALLY_W:0]    trial;

    assign shifted = {rem_reg, quo_reg[TIME_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TIME_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[TALLY_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[TALLY_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a run");
    a_no_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> req.divisor != '0)
        else $error("divider started with zero divisor");
`endif

endmodule
`default_nettype wire

/* rtl/pulse_burst_pattern_decoder_top.sv */
// Top level of the pulse burst pattern decoder: debounce, burst tally and pattern scan.
`default_nettype none
// Each accepted item returns exactly one result. An item that closes no burst goes
// through capture, debounce, gap check and output load (a disabled block skips debounce
// and gap check); an item that closes a burst adds the bit-serial divide of the width
// sum by the pulse count and a scan of one pattern slot per cycle. The input is taken
// only when the sequencer is idle, and a new item may be taken while the previous result
// still waits on the output register.
module pulse_burst_pattern_decoder_top
#(
    parameter int unsigned PATTERN_SLOTS = 6
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pbpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pbpd_pkg::PAIR_W-1:0]    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [pbpd_pkg::TIME_W-1:0]    now_time,
    input  wire logic                           pin_level,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                burst_done,
    output logic [pbpd_pkg::TALLY_W-1:0]        burst_pulses,
    output logic [pbpd_pkg::MS_W-1:0]           average_width,
    output logic                                pattern_hit,
    output logic [7:0]                          preset_number,
    output logic [pbpd_pkg::TIME_W-1:0]         burst_total,
    output logic [pbpd_pkg::TIME_W-1:0]         match_total
);
    import pbpd_pkg::*;

    localparam int unsigned SLOT_W = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;

    // configuration
    logic                 enable_reg;
    logic                 active_low_reg;
    logic [MS_W-1:0]      debounce_reg;
    logic [MS_W-1:0]      gap_reg;
    logic [MS_W-1:0]      tol_reg;
    logic [PAIR_W-1:0]    pair_reg [PAIR_COUNT];
    logic [SLOT_WORD_W-1:0] slot_word [PATTERN_SLOTS];

    // decoder state
    pbpd_state_t          state_reg, state_next;
    logic                 raw_reg, raw_next;
    logic                 clean_reg, clean_next;
    logic [TIME_W-1:0]    edge_reg, edge_next;
    logic [TIME_W-1:0]    start_reg, start_next;
    logic [TIME_W-1:0]    end_reg, end_next;
    logic                 pending_reg, pending_next;
    logic [TALLY_W-1:0]   tally_reg, tally_next;
    logic [TIME_W-1:0]    sum_reg, sum_next;
    logic [TIME_W-1:0]    bursts_reg, bursts_next;
    logic [TIME_W-1:0]    matches_reg, matches_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    // current item and working result
    logic [TIME_W-1:0]    now_reg, now_next;
    logic                 act_reg, act_next;
    logic                 rdone_reg, rdone_next;
    logic [TALLY_W-1:0]   rcnt_reg, rcnt_next;
    logic [MS_W-1:0]      ravg_reg, ravg_next;
    logic                 rhit_reg, rhit_next;
    logic [7:0]           rpreset_reg, rpreset_next;

    // output register
    logic                 ovalid_reg, ovalid_next;
    logic                 odone_reg, ocnt_load;
    logic [TALLY_W-1:0]   ocnt_reg;
    logic [MS_W-1:0]      oavg_reg;
    logic                 ohit_reg;
    logic [7:0]           opreset_reg;
    logic [TIME_W-1:0]    obursts_reg, omatches_reg;

    pbpd_div_req_t        div_req;
    logic                 div_done;
    logic [TIME_W-1:0]    div_quo;

    logic [TIME_W-1:0]    edge_eff, settle_diff, gap_diff;
    logic [SLOT_WORD_W-1:0] cur_word;
    logic [TALLY_W-1:0]   pat_cnt;
    logic [MS_W-1:0]      pat_width, width_diff;
    logic                 slot_match;

    genvar g;
    generate
        for (g = 0; g < PATTERN_SLOTS; g++)
        begin : g_slot
            assign slot_word[g] = pair_reg[g / 2][(g % 2) * SLOT_WORD_W +: SLOT_WORD_W];
        end
    endgenerate

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            active_low_reg <= 1'b1;
            debounce_reg   <= 16'd30;
            gap_reg        <= 16'd600;
            tol_reg        <= 16'd60;
            for (int i = 0; i < PAIR_COUNT; i++)
            begin
                pair_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BLOCK_ENABLE:    enable_reg     <= cfg_data[0];
                CFG_ACTIVE_LOW:      active_low_reg <= cfg_data[0];
                CFG_DEBOUNCE_TIME:   debounce_reg   <= cfg_data[MS_W-1:0];
                CFG_GAP_TIMEOUT:     gap_reg        <= cfg_data[MS_W-1:0];
                CFG_WIDTH_TOLERANCE: tol_reg        <= cfg_data[MS_W-1:0];
                CFG_PATTERN_PAIR_0:  pair_reg[0]    <= cfg_data;
                CFG_PATTERN_PAIR_1:  pair_reg[1]    <= cfg_data;
                CFG_PATTERN_PAIR_2:  pair_reg[2]    <= cfg_data;
                default: ;
            endcase
        end
    end

    pbpd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign edge_eff    = (act_reg != raw_reg) ? now_reg : edge_reg;
    assign settle_diff = now_reg - edge_eff;
    assign gap_diff    = now_reg - end_reg;

    assign cur_word   = slot_word[slot_reg];
    assign pat_cnt    = cur_word[7:0];
    assign pat_width  = cur_word[23:8];
    assign width_diff = (ravg_reg >= pat_width) ? (ravg_reg - pat_width)
                                                : (pat_width - ravg_reg);
    assign slot_match = (pat_cnt != '0) && (pat_cnt == rcnt_reg) && (width_diff <= tol_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign ocnt_load = (state_reg == ST_FIN) && (!ovalid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        raw_next     = raw_reg;
        clean_next   = clean_reg;
        edge_next    = edge_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        pending_next = pending_reg;
        tally_next   = tally_reg;
        sum_next     = sum_reg;
        bursts_next  = bursts_reg;
        matches_next = matches_reg;
        slot_next    = slot_reg;
        now_next     = now_reg;
        act_next     = act_reg;
        rdone_next   = rdone_reg;
        rcnt_next    = rcnt_reg;
        ravg_next    = ravg_reg;
        rhit_next    = rhit_reg;
        rpreset_next = rpreset_reg;
        ovalid_next  = ovalid_reg;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = tally_reg;

        if (out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next     = now_time;
                    act_next     = pin_level ^ active_low_reg;
                    rdone_next   = 1'b0;
                    rcnt_next    = '0;
                    ravg_next    = '0;
                    rhit_next    = 1'b0;
                    rpreset_next = '0;
                    state_next   = enable_reg ? ST_DEB : ST_FIN;
                end
            end
            ST_DEB:
            begin
                raw_next  = act_reg;
                edge_next = edge_eff;
                if (act_reg != clean_reg && settle_diff >= {16'd0, debounce_reg})
                begin
                    clean_next = act_reg;
                    if (act_reg)
                    begin
                        start_next = now_reg;
                    end
                    else
                    begin
                        if (tally_reg < TALLY_LIMIT)
                        begin
                            tally_next = tally_reg + 1'b1;
                        end
                        sum_next     = sum_reg + (now_reg - start_reg);
                        end_next     = now_reg;
                        pending_next = 1'b1;
                    end
                end
                state_next = ST_GAP;
            end
            ST_GAP:
            begin
                state_next = ST_FIN;
                if (pending_reg && !clean_reg && gap_diff >= {16'd0, gap_reg})
                begin
                    if (tally_reg != '0)
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        pending_next = 1'b0;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    rdone_next  = 1'b1;
                    rcnt_next   = tally_reg;
                    ravg_next   = div_quo[MS_W-1:0];
                    bursts_next = bursts_reg + 1'b1;
                    slot_next   = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (slot_match || slot_reg == SLOT_W'(PATTERN_SLOTS - 1))
                begin
                    if (slot_match)
                    begin
                        rhit_next    = 1'b1;
                        rpreset_next = cur_word[31:24];
                        matches_next = matches_reg + 1'b1;
                    end
                    tally_next   = '0;
                    sum_next     = '0;
                    pending_next = 1'b0;
                    state_next   = ST_FIN;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (ocnt_load)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            raw_reg     <= 1'b0;
            clean_reg   <= 1'b0;
            edge_reg    <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            pending_reg <= 1'b0;
            tally_reg   <= '0;
            sum_reg     <= '0;
            bursts_reg  <= '0;
            matches_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            raw_reg     <= raw_next;
            clean_reg   <= clean_next;
            edge_reg    <= edge_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            pending_reg <= pending_next;
            tally_reg   <= tally_next;
            sum_reg     <= sum_next;
            bursts_reg  <= bursts_next;
            matches_reg <= matches_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        now_reg     <= now_next;
        act_reg     <= act_next;
        rdone_reg   <= rdone_next;
        rcnt_reg    <= rcnt_next;
        ravg_reg    <= ravg_next;
        rhit_reg    <= rhit_next;
        rpreset_reg <= rpreset_next;
        if (ocnt_load)
        begin
            odone_reg    <= rdone_reg;
            ocnt_reg     <= rcnt_reg;
            oavg_reg     <= ravg_reg;
            ohit_reg     <= rhit_reg;
            opreset_reg  <= rpreset_reg;
            obursts_reg  <= bursts_reg;
            omatches_reg <= matches_reg;
        end
    end

    assign out_valid     = ovalid_reg;
    assign burst_done    = odone_reg;
    assign burst_pulses  = ocnt_reg;
    assign average_width = oavg_reg;
    assign pattern_hit   = ohit_reg;
    assign preset_number = opreset_reg;
    assign burst_total   = obursts_reg;
    assign match_total   = omatches_reg;

`ifndef SYNTHESIS
    a_hit_needs_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pattern_hit |-> burst_done)
        else $error("pattern hit without a closed burst");
    a_burst_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && burst_done |-> burst_pulses != '0 && burst_pulses <= TALLY_LIMIT)
        else $error("closed burst count out of range");
    a_match_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(matches_reg) |-> $past(state_reg) == ST_SCAN)
        else $error("match total moved outside the scan");
    a_tally_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && state_next == ST_FIN |=> tally_reg == '0 && !pending_reg)
        else $error("burst state not cleared after scan");
`endif

endmodule
`default_nettype wire
